// File: hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and functions for the odometry block
// Holds the sequencer states, the CORDIC arctangent table and the small
// rounding and saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

  // Number of CORDIC micro-rotations, one per clock cycle (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int CORD_IT_W     = (CORDIC_STAGES > 16) ? 5 : 4;

  // Serial multiplier: 17 multiplier bits, the top one carries negative weight.
  localparam int MUL_STEPS = 17;
  localparam int MUL_CNT_W = 5;

  // Datapath widths.
  localparam int CX_W  = 33;   // CORDIC x and y, Q2.30 with headroom
  localparam int CZ_W  = 26;   // CORDIC angle, 2^24 units per turn
  localparam int ACC_W = 64;   // product accumulator

  localparam logic signed [CX_W-1:0] CORDIC_K = 33'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] REG_INIT_X       = 2'd0;
  localparam logic [1:0] REG_INIT_Y       = 2'd1;
  localparam logic [1:0] REG_INIT_HEADING = 2'd2;
  localparam logic [1:0] REG_HEADING_GAIN = 2'd3;

  // Input operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GMUL,
    ST_MINIT,
    ST_CORD1,
    ST_CFIN,
    ST_MXC,
    ST_MXD,
    ST_MYC,
    ST_MYD,
    ST_MHD,
    ST_COMMIT,
    ST_QINIT,
    ST_QCOR,
    ST_DONE
  } state_t;

  // Arctangent of 2^-i in units of 2^24 per turn.
  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CZ_W-1:0] v;
    unique case (idx)
      5'd0:  v = 26'sd2097152;
      5'd1:  v = 26'sd1238021;
      5'd2:  v = 26'sd654136;
      5'd3:  v = 26'sd332050;
      5'd4:  v = 26'sd166669;
      5'd5:  v = 26'sd83416;
      5'd6:  v = 26'sd41718;
      5'd7:  v = 26'sd20860;
      5'd8:  v = 26'sd10430;
      5'd9:  v = 26'sd5215;
      5'd10: v = 26'sd2608;
      5'd11: v = 26'sd1304;
      5'd12: v = 26'sd652;
      5'd13: v = 26'sd326;
      5'd14: v = 26'sd163;
      5'd15: v = 26'sd81;
      5'd16: v = 26'sd41;
      5'd17: v = 26'sd20;
      5'd18: v = 26'sd10;
      5'd19: v = 26'sd5;
      5'd20: v = 26'sd3;
      5'd21: v = 26'sd1;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Q2.30 to Q1.14 with rounding, clamped to plus or minus one.
  function automatic logic [15:0] to_q14(input logic signed [CX_W-1:0] a);
    logic signed [CX_W:0]  sum;
    logic signed [17:0]    r;
    logic [15:0]           res;
    sum = {a[CX_W-1], a} + 34'sd32768;
    r   = sum[CX_W:16];
    if (r > 18'sd16384) begin
      res = 16'sd16384;
    end else if (r < -18'sd16384) begin
      res = -16'sd16384;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  // Turn rate: product shifted down by 12 and saturated to 20 bits.
  function automatic logic [19:0] sat_rate(input logic signed [32:0] g);
    logic signed [20:0] t;
    logic [19:0]        res;
    t = g[32:12];
    if (t > 21'sd524287) begin
      res = 20'h7FFFF;
    end else if (t < -21'sd524288) begin
      res = 20'h80000;
    end else begin
      res = t[19:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry: dead-reckoning pose integrator for a two-wheel robot
// Integrates x, y and heading from wheel speeds with one iterative CORDIC
// and one shared bit-serial multiplier, and reports the heading quaternion.
// ----------------------------------------------------------------------------
// A load word (tuser = 1) copies the initial pose registers into the pose
// and then only runs the quaternion CORDIC; a tick word before any load
// takes the same path. A tick word on a loaded pose runs six passes of
// the shared shift-and-add multiplier (gain, then v*cos*dt, v*sin*dt and
// the heading step) and two 16-step CORDIC runs. One word is worked on at a
// time; the result sits in an output register, so the next word is taken
// while the previous result still waits downstream. If a tick would carry
// x or y outside the signed 32-bit range the old pose is kept and
// overflow_kept is raised in that result.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  // Input stream.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: left_speed[15:0], right_speed[31:16], time_step[47:32]
  input  wire logic [47:0]  in_tdata,
  // tuser: opcode[0]
  input  wire logic         in_tuser,
  // Result stream.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: pos_x[31:0], pos_y[63:32], heading[79:64], linear_speed[95:80],
  // angular_rate[115:96], quat_z[131:116], quat_w[147:132],
  // pose_valid[148], overflow_kept[149], zero fill[151:150]
  output logic [151:0]      out_tdata
);
  import ddo_pkg::*;

  // Configuration registers.
  logic [31:0] init_x_r, init_y_r;
  logic [15:0] init_heading_r, heading_gain_r;

  // Pose state.
  logic [31:0] pose_x_r, pose_y_r;
  logic [15:0] pose_heading_r;
  logic        pose_loaded_r;

  // Sequencer.
  state_t state_r, state_nxt;

  // Latched word and intermediate results.
  logic [15:0]        dt_r;
  logic [15:0]        v_r;
  logic signed [32:0] gdiff_r;
  logic               neg_r;
  logic signed [CX_W-1:0] s_r;
  logic signed [21:0] dx_r, dy_r;
  logic [15:0]        dh_r;
  logic               ovf_r;

  // CORDIC registers.
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [CZ_W-1:0] cz_r;
  logic [CORD_IT_W-1:0]   it_r;

  // Serial multiplier registers.
  logic signed [ACC_W-1:0] macc_r, ma_r;
  logic signed [16:0]      mb_r;
  logic [MUL_CNT_W-1:0]    cnt_r;

  // Output register.
  logic         out_valid_r;
  logic [151:0] out_data_r;

  // Control decoded from the state.
  logic accept, mul_last, cord_last, emit;

  // ---------------------------------------------------------------------
  // Combinational datapath helpers.
  // ---------------------------------------------------------------------
  logic signed [16:0]      lsp, rsp, sum17, diff17;
  logic signed [16:0]      fold_a;
  logic                    fold_neg;
  logic signed [CX_W-1:0]  cdx, cdy, cx_nxt, cy_nxt;
  logic signed [CZ_W-1:0]  cz_nxt;
  logic signed [ACC_W-1:0] mterm, macc_nxt;
  logic signed [33:0]      nx, ny;
  logic                    nx_ovf, ny_ovf;

  assign lsp    = {in_tdata[15], in_tdata[15:0]};
  assign rsp    = {in_tdata[31], in_tdata[31:16]};
  assign sum17  = rsp + lsp;
  assign diff17 = rsp - lsp;

  // Fold the heading into the quarter turns either side of zero.
  always_comb begin
    fold_a   = {pose_heading_r[15], pose_heading_r};
    fold_neg = 1'b0;
    if (fold_a > 17'sd16384) begin
      fold_a   = fold_a - 17'sd32768;
      fold_neg = 1'b1;
    end else if (fold_a < -17'sd16384) begin
      fold_a   = fold_a + 17'sd32768;
      fold_neg = 1'b1;
    end
  end

  // One CORDIC micro-rotation.
  always_comb begin
    cdx = cy_r >>> it_r;
    cdy = cx_r >>> it_r;
    if (!cz_r[CZ_W-1]) begin
      cx_nxt = cx_r - cdx;
      cy_nxt = cy_r + cdy;
      cz_nxt = cz_r - atan_lut(5'(it_r));
    end else begin
      cx_nxt = cx_r + cdx;
      cy_nxt = cy_r - cdy;
      cz_nxt = cz_r + atan_lut(5'(it_r));
    end
  end

  // One shift-and-add step; the last multiplier bit has negative weight.
  assign mterm    = mb_r[0] ? ma_r : '0;
  assign macc_nxt = mul_last ? (macc_r - mterm) : (macc_r + mterm);

  // New position and range check.
  assign nx     = {{2{pose_x_r[31]}}, pose_x_r} + {{12{dx_r[21]}}, dx_r};
  assign ny     = {{2{pose_y_r[31]}}, pose_y_r} + {{12{dy_r[21]}}, dy_r};
  assign nx_ovf = (nx[33:31] != 3'b000) && (nx[33:31] != 3'b111);
  assign ny_ovf = (ny[33:31] != 3'b000) && (ny[33:31] != 3'b111);

  // ---------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_LOAD || !pose_loaded_r) begin
            state_nxt = ST_QINIT;
          end else begin
            state_nxt = ST_GMUL;
          end
        end
      end
      ST_GMUL:   if (mul_last) state_nxt = ST_MINIT;
      ST_MINIT:  state_nxt = ST_CORD1;
      ST_CORD1:  if (cord_last) state_nxt = ST_CFIN;
      ST_CFIN:   state_nxt = ST_MXC;
      ST_MXC:    if (mul_last) state_nxt = ST_MXD;
      ST_MXD:    if (mul_last) state_nxt = ST_MYC;
      ST_MYC:    if (mul_last) state_nxt = ST_MYD;
      ST_MYD:    if (mul_last) state_nxt = ST_MHD;
      ST_MHD:    if (mul_last) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_QINIT;
      ST_QINIT:  state_nxt = ST_QCOR;
      ST_QCOR:   if (cord_last) state_nxt = ST_DONE;
      ST_DONE:   if (emit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control outputs of the sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    accept    = in_tready && in_tvalid;
    mul_last  = (cnt_r == MUL_CNT_W'(MUL_STEPS - 1));
    cord_last = (it_r == CORD_IT_W'(CORDIC_STAGES - 1));
    emit      = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
      pose_loaded_r  <= 1'b0;
      init_x_r       <= '0;
      init_y_r       <= '0;
      init_heading_r <= '0;
      heading_gain_r <= 16'd28973;
    end else begin
      state_r <= state_nxt;

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Register writes.
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_INIT_X:       init_x_r       <= cfg_wdata;
          REG_INIT_Y:       init_y_r       <= cfg_wdata;
          REG_INIT_HEADING: init_heading_r <= cfg_wdata[15:0];
          REG_HEADING_GAIN: heading_gain_r <= cfg_wdata[15:0];
          default:          ;
        endcase
      end

      // Pose load and pose update.
      if (accept && in_tuser == OP_LOAD) begin
        pose_x_r       <= init_x_r;
        pose_y_r       <= init_y_r;
        pose_heading_r <= init_heading_r;
        pose_loaded_r  <= 1'b1;
      end else if (state_r == ST_COMMIT && !nx_ovf && !ny_ovf) begin
        pose_x_r       <= nx[31:0];
        pose_y_r       <= ny[31:0];
        pose_heading_r <= pose_heading_r + dh_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dt_r    <= in_tdata[47:32];
          gdiff_r <= '0;
          ovf_r   <= 1'b0;
          v_r     <= (in_tuser == OP_LOAD || !pose_loaded_r) ? 16'd0 : sum17[16:1];
          ma_r    <= ACC_W'(diff17);
          mb_r    <= {1'b0, heading_gain_r};
          macc_r  <= '0;
          cnt_r   <= '0;
        end
      end
      ST_GMUL, ST_MXC, ST_MXD, ST_MYC, ST_MYD, ST_MHD: begin
        if (mul_last) begin
          // Last step: keep the product and set up the next pass.
          macc_r <= '0;
          cnt_r  <= '0;
          unique case (state_r)
            ST_GMUL: gdiff_r <= macc_nxt[32:0];
            ST_MXC: begin
              ma_r <= macc_nxt;
              mb_r <= {1'b0, dt_r};
            end
            ST_MXD: begin
              dx_r <= macc_nxt[63:42];
              ma_r <= ACC_W'(s_r);
              mb_r <= {v_r[15], v_r};
            end
            ST_MYC: begin
              ma_r <= macc_nxt;
              mb_r <= {1'b0, dt_r};
            end
            ST_MYD: begin
              dy_r <= macc_nxt[63:42];
              ma_r <= ACC_W'(gdiff_r);
              mb_r <= {1'b0, dt_r};
            end
            default: dh_r <= macc_nxt[43:28];
          endcase
        end else begin
          macc_r <= macc_nxt;
          ma_r   <= ma_r <<< 1;
          mb_r   <= mb_r >>> 1;
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      ST_MINIT: begin
        cx_r  <= CORDIC_K;
        cy_r  <= '0;
        cz_r  <= {fold_a[16], fold_a, 8'd0};
        it_r  <= '0;
        neg_r <= fold_neg;
      end
      ST_CORD1, ST_QCOR: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
        it_r <= it_r + 1'b1;
      end
      ST_CFIN: begin
        // Undo the fold, then start v * cos.
        ma_r   <= ACC_W'(neg_r ? -cx_r : cx_r);
        s_r    <= neg_r ? -cy_r : cy_r;
        mb_r   <= {v_r[15], v_r};
        macc_r <= '0;
        cnt_r  <= '0;
      end
      ST_COMMIT: begin
        ovf_r <= nx_ovf || ny_ovf;
      end
      ST_QINIT: begin
        cx_r <= CORDIC_K;
        cy_r <= '0;
        cz_r <= {{3{pose_heading_r[15]}}, pose_heading_r, 7'd0};
        it_r <= '0;
      end
      ST_DONE: begin
        if (emit) begin
          out_data_r <= {2'b00, ovf_r, pose_loaded_r,
                         to_q14(cx_r), to_q14(cy_r),
                         sat_rate(gdiff_r), v_r,
                         pose_heading_r, pose_y_r, pose_x_r};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker: port-level checks for the odometry block
// Watches the stream ports over time and flags results that break the
// block's rules on handshake, busy time and flag consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [151:0] out_tdata
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  // In the cycle after a word is taken the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again straight after acceptance");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Without a loaded pose the speeds and the overflow flag are zero.
  a_unloaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[148] |->
      out_tdata[95:80] == 16'd0 && out_tdata[115:96] == 20'd0 && !out_tdata[149])
    else $error("speeds reported without a loaded pose");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
